@@ rtl/pcm_rms_peak_level_meter_unit_assert.svh @@
// assertion macros for the pcm rms and peak level meter
// used by the port checker; no other dependencies
`ifndef PCM_RMS_PEAK_LEVEL_METER_UNIT_ASSERT_SVH
`define PCM_RMS_PEAK_LEVEL_METER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PRMS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PRMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/prms_pkg.sv @@
// shared types and constants of the pcm rms and peak level meter
// no dependencies
`default_nettype none

package prms_pkg;

  // default accumulator widths
  localparam int unsigned SUM_BITS_DEF   = 48;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // full scale in sample units
  localparam int unsigned FULL_SCALE = 32768;

  // input beat kinds
  typedef enum logic [1:0] {
    KIND_PCM   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_LINK  = 2'd2,
    KIND_AUDIO = 2'd3
  } kind_e;

  // level status codes of a result beat
  typedef enum logic [1:0] {
    LVL_OBSERVED    = 2'd0,
    LVL_NO_PCM      = 2'd1,
    LVL_NOT_STARTED = 2'd2
  } level_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_SQINIT,
    S_SQRT,
    S_DONE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic take;       // input beat accepted this cycle
    logic load;       // snapshot window, clear accumulators
    logic div_step;   // one quotient bit
    logic sq_init;    // move quotient into root unit
    logic sq_step;    // one root bit
    logic res_write;  // load output register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic win_empty;  // no sample in the current window
    logic div_last;   // last quotient bit this cycle
    logic sq_last;    // last root bit this cycle
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/prms_datapath.sv @@
// datapath: window accumulators, serial divider, serial square root, output register
// depends on prms_pkg
`default_nettype none

module prms_datapath #(
  parameter int unsigned SUM_BITS   = prms_pkg::SUM_BITS_DEF,
  parameter int unsigned COUNT_BITS = prms_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire prms_pkg::dp_cmd_t cmd_i,
  output prms_pkg::dp_sts_t      sts_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic              flag_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic                   route_connected_o,
  output logic [1:0]             level_status_o,
  output logic [15:0]            rms_level_o,
  output logic [15:0]            peak_level_o
);
  import prms_pkg::*;

  localparam int unsigned RW   = (SUM_BITS + 1) / 2;
  localparam int unsigned RADW = 2 * RW;
  localparam int unsigned CNTW = $clog2(SUM_BITS);

  // accumulators and flags
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [15:0]           peak_q, peak_d;
  logic                  link_q, link_d;
  logic                  audio_q, audio_d;

  // square stage
  logic        sq_vld_q;
  logic [15:0] mag_q;
  logic [31:0] sq_q;
  logic [15:0] mag;

  // divider
  logic [SUM_BITS-1:0]   dq_q, dq_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] dvs_q, dvs_d;
  logic [15:0]           pk_snap_q, pk_snap_d;
  logic                  empty_q, empty_d;

  // root unit
  logic [RADW-1:0] rad_q, rad_d;
  logic [RW-1:0]   root_q, root_d;
  logic [RW:0]     srem_q, srem_d;

  logic [CNTW-1:0] cnt_q, cnt_d;

  // output register
  logic        ovld_q, ovld_d;
  logic        oroute_q, oroute_d;
  level_e      ostat_q, ostat_d;
  logic [15:0] orms_q, orms_d;
  logic [15:0] opeak_q, opeak_d;

  // combinational temporaries
  logic [SUM_BITS:0]   sum_ext;
  logic [COUNT_BITS:0] rem_sh, rem_diff;
  logic                div_ge;
  logic [RW+2:0]       rem_t, trial, sq_diff;
  logic                sq_ge;
  logic [15:0]         rms_clamped;

  // magnitude of the incoming sample; minus full scale maps to 0x8000
  assign mag = sample_i[15] ? 16'(~sample_i + 16'sd1) : 16'(sample_i);

  // square stage: one multiply, registered before the accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= cmd_i.take && (kind_i == KIND_PCM);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag;
    sq_q  <= 32'(mag) * 32'(mag);
  end

  // accumulate, saturate, track peak, event flags
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    peak_d  = peak_q;
    link_d  = link_q;
    audio_d = audio_q;
    sum_ext = {1'b0, sum_q} + (SUM_BITS+1)'(sq_q);
    if (sq_vld_q) begin
      sum_d = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
      if (count_q != '1) begin
        count_d = count_q + COUNT_BITS'(1);
      end
      if (mag_q > peak_q) begin
        peak_d = mag_q;
      end
    end
    if (cmd_i.take && (kind_i == KIND_LINK)) begin
      link_d = flag_i;
      if (!flag_i) begin
        audio_d = 1'b0;
      end
    end
    if (cmd_i.take && (kind_i == KIND_AUDIO)) begin
      audio_d = flag_i;
    end
    if (cmd_i.load) begin
      sum_d   = '0;
      count_d = '0;
      peak_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      peak_q  <= '0;
      link_q  <= 1'b0;
      audio_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      link_q  <= link_d;
      audio_q <= audio_d;
    end
  end

  // restoring divider and digit-by-digit root, one bit per cycle
  always_comb begin
    dq_d      = dq_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    pk_snap_d = pk_snap_q;
    empty_d   = empty_q;
    rad_d     = rad_q;
    root_d    = root_q;
    srem_d    = srem_q;
    cnt_d     = cnt_q;

    rem_sh   = {rem_q, dq_q[SUM_BITS-1]};
    rem_diff = rem_sh - {1'b0, dvs_q};
    div_ge   = rem_sh >= {1'b0, dvs_q};

    rem_t   = {srem_q, rad_q[RADW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    sq_diff = rem_t - trial;
    sq_ge   = rem_t >= trial;

    if (cmd_i.load) begin
      dq_d      = sum_q;
      rem_d     = '0;
      dvs_d     = count_q;
      pk_snap_d = peak_q;
      empty_d   = (count_q == '0);
      cnt_d     = '0;
    end
    if (cmd_i.div_step) begin
      dq_d  = {dq_q[SUM_BITS-2:0], div_ge};
      rem_d = div_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      cnt_d = cnt_q + CNTW'(1);
    end
    if (cmd_i.sq_init) begin
      rad_d  = RADW'(dq_q);
      root_d = '0;
      srem_d = '0;
      cnt_d  = '0;
    end
    if (cmd_i.sq_step) begin
      rad_d  = {rad_q[RADW-3:0], 2'b00};
      root_d = {root_q[RW-2:0], sq_ge};
      srem_d = sq_ge ? sq_diff[RW:0] : rem_t[RW:0];
      cnt_d  = cnt_q + CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    pk_snap_q <= pk_snap_d;
    empty_q   <= empty_d;
    rad_q     <= rad_d;
    root_q    <= root_d;
    srem_q    <= srem_d;
  end

  // clamp the root to full scale
  assign rms_clamped = (root_q > RW'(FULL_SCALE)) ? 16'(FULL_SCALE) : root_q[15:0];

  // output register, holds a beat until taken
  always_comb begin
    ovld_d   = ovld_q && out_stall_i;
    oroute_d = oroute_q;
    ostat_d  = ostat_q;
    orms_d   = orms_q;
    opeak_d  = opeak_q;
    if (cmd_i.res_write) begin
      ovld_d   = 1'b1;
      oroute_d = link_q;
      if (empty_q) begin
        ostat_d = audio_q ? LVL_NO_PCM : LVL_NOT_STARTED;
        orms_d  = '0;
        opeak_d = '0;
      end else begin
        ostat_d = LVL_OBSERVED;
        orms_d  = rms_clamped;
        opeak_d = pk_snap_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oroute_q <= oroute_d;
    ostat_q  <= ostat_d;
    orms_q   <= orms_d;
    opeak_q  <= opeak_d;
  end

  // status back to the controller
  assign sts_o.win_empty = (count_q == '0);
  assign sts_o.div_last  = (cnt_q == CNTW'(SUM_BITS - 1));
  assign sts_o.sq_last   = (cnt_q == CNTW'(RW - 1));
  assign sts_o.out_free  = !ovld_q || !out_stall_i;

  assign out_valid_o       = ovld_q;
  assign route_connected_o = oroute_q;
  assign level_status_o    = ostat_q;
  assign rms_level_o       = orms_q;
  assign peak_level_o      = opeak_q;

endmodule

`default_nettype wire

@@ rtl/prms_ctrl.sv @@
// controller: sequences window snapshot, divide, root and result write
// depends on prms_pkg
`default_nettype none

module prms_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        kind_i,
  output logic                   in_stall_o,
  input  wire prms_pkg::dp_sts_t sts_i,
  output prms_pkg::dp_cmd_t      cmd_o
);
  import prms_pkg::*;

  state_e state_q, state_d;
  logic   take;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign take       = in_valid_i && (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.take = take;
    case (state_q)
      S_IDLE: begin
        if (take && (kind_i == KIND_TICK)) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.win_empty ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_SQINIT;
        end
      end
      S_SQINIT: begin
        cmd_o.sq_init = 1'b1;
        state_d       = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_write = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pcm_rms_peak_level_meter_unit.sv @@
// pcm level meter: samples, events and window ticks take one beat a cycle while idle.
// a tick holds the input while the window is evaluated: one quotient bit per cycle in
// the divider, then one root bit per cycle; an empty window skips both steps.
// the result beat then waits in an output register.
// reset (rst_ni low, asynchronous) clears accumulators, link and audio flags,
// the controller and the output valid.
`default_nettype none

module pcm_rms_peak_level_meter_unit #(
  parameter int unsigned SUM_BITS   = prms_pkg::SUM_BITS_DEF,
  parameter int unsigned COUNT_BITS = prms_pkg::COUNT_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               flag_i,
  input  wire logic               buffer_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    route_connected_o,
  output logic [1:0]              level_status_o,
  output logic [15:0]             rms_level_o,
  output logic [15:0]             peak_level_o
);
  import prms_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // buffer_end_i marks buffer boundaries only and leaves the level untouched

  // sequencer
  prms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // accumulators, divider, root, output register
  prms_datapath #(
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (kind_i),
    .sample_i          (sample_i),
    .flag_i            (flag_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .route_connected_o (route_connected_o),
    .level_status_o    (level_status_o),
    .rms_level_o       (rms_level_o),
    .peak_level_o      (peak_level_o)
  );

endmodule

`default_nettype wire

@@ rtl/prms_checker.sv @@
// port checker for the pcm level meter, bound to the top level
// depends on prms_pkg and pcm_rms_peak_level_meter_unit_assert.svh
`default_nettype none

`include "pcm_rms_peak_level_meter_unit_assert.svh"

module prms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  kind_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        route_connected_o,
  input wire logic [1:0]  level_status_o,
  input wire logic [15:0] rms_level_o,
  input wire logic [15:0] peak_level_o
);
  import prms_pkg::*;

  // a stalled result beat holds
  `PRMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(level_status_o) && $stable(rms_level_o) && $stable(peak_level_o) && $stable(route_connected_o), "result beat changed while stalled")

  // an accepted tick closes the input while the window is evaluated
  `PRMS_ASSERT_NEXT(a_tick_stall, clk_i, rst_ni, in_valid_i && !in_stall_o && (kind_i == KIND_TICK), in_stall_o, "input open right after a tick")

  // a new result only follows a busy period
  `PRMS_ASSERT_NOW(a_res_after_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without evaluation")

  // empty windows report zero levels
  `PRMS_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_o && (level_status_o != LVL_OBSERVED), (rms_level_o == 16'd0) && (peak_level_o == 16'd0), "levels set on empty window")

  // levels never pass full scale
  `PRMS_ASSERT_NOW(a_full_scale, clk_i, rst_ni, out_valid_o, (rms_level_o <= 16'(FULL_SCALE)) && (peak_level_o <= 16'(FULL_SCALE)), "level above full scale")

endmodule

bind pcm_rms_peak_level_meter_unit prms_checker u_prms_checker (.*);

`default_nettype wire
